// ----- rtl/core/utt_pkg.sv -----
package utt_pkg;

   localparam int MAX_TEXT_BYTES = 1024;

   localparam int CAP_W       = 11;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int CMD_DEPTH   = 4;
   localparam int CMD_PTR_W   = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W   = $clog2(CMD_DEPTH + 1);

   localparam logic [CSR_ADDR_W-1:0] CSR_CAPACITY_ADDR = 3'd0;
   localparam logic [CAP_W-1:0]      CAPACITY_RESET    = 11'd1024;

   localparam logic [5:0]  HIGH_SURR_TAG = 6'b110110;
   localparam logic [5:0]  LOW_SURR_TAG  = 6'b110111;
   localparam logic [20:0] SUPP_BASE     = 21'h10000;
   localparam logic [20:0] REPLACEMENT   = 21'h00fffd;

   typedef struct packed {
      logic [20:0]      cp1;
      logic [2:0]       len1;
      logic [15:0]      cp2;
      logic [2:0]       len2;
      logic             fin;
      logic [CAP_W-1:0] length;
   } cmd_type;

   function automatic logic [2:0] utf8_len(input logic [20:0] cp);
      logic [2:0] len;
      if (cp <= 21'h7f) begin
         len = 3'd1;
      end else if (cp <= 21'h7ff) begin
         len = 3'd2;
      end else if (cp <= 21'hffff) begin
         len = 3'd3;
      end else begin
         len = 3'd4;
      end
      return len;
   endfunction

   function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [2:0] len,
                                            input logic [1:0] idx);
      logic [7:0] b;
      b = 8'h00;
      case (len)
         3'd1: b = cp[7:0];
         3'd2: b = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
         3'd3: begin
            case (idx)
               2'd0:    b = {4'b1110, cp[15:12]};
               2'd1:    b = {2'b10, cp[11:6]};
               default: b = {2'b10, cp[5:0]};
            endcase
         end
         3'd4: begin
            case (idx)
               2'd0:    b = {5'b11110, cp[20:18]};
               2'd1:    b = {2'b10, cp[17:12]};
               2'd2:    b = {2'b10, cp[11:6]};
               default: b = {2'b10, cp[5:0]};
            endcase
         end
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

// ----- rtl/core/utt_front.sv -----
module utt_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [utt_pkg::CAP_W-1:0] capacity,
   input  logic                      accept,
   input  logic [15:0]               code_unit,
   input  logic                      final_unit,
   output logic                      cmd_wr_en,
   output utt_pkg::cmd_type          cmd_wr_data
);
   import utt_pkg::*;

   logic             high_pending_ff, high_pending_in;
   logic [9:0]       high_bits_ff, high_bits_in;
   logic [CAP_W-1:0] bytes_written_ff, bytes_written_in;
   logic             stopped_ff, stopped_in;

   logic             is_high, is_low, fresh;
   logic             has1, has2;
   logic [20:0]      cp1;
   logic [15:0]      cp2;
   logic [2:0]       len1, len2;
   logic [CAP_W-1:0] cap_eff;
   logic [CAP_W:0]   sum1, sum2;
   logic             emit1, emit2, stop1, stop2;
   logic [CAP_W-1:0] bw1, bw2;

   always_comb begin
      is_high = (code_unit[15:10] == HIGH_SURR_TAG);
      is_low  = (code_unit[15:10] == LOW_SURR_TAG);
      fresh   = !(high_pending_ff && is_low);
      cap_eff = (capacity > CAP_W'(MAX_TEXT_BYTES)) ? CAP_W'(MAX_TEXT_BYTES) : capacity;

      has1 = high_pending_ff;
      cp1  = is_low ? (SUPP_BASE + {11'd0, high_bits_ff[9:0]} * 21'd1024
                       + {11'd0, code_unit[9:0]})
                    : REPLACEMENT;
      len1 = is_low ? 3'd4 : 3'd3;

      has2 = fresh && !(is_high && !final_unit);
      cp2  = (is_high || is_low) ? REPLACEMENT[15:0] : code_unit;
      len2 = utf8_len({5'd0, cp2});

      sum1  = {1'b0, bytes_written_ff} + {{(CAP_W-2){1'b0}}, len1};
      emit1 = has1 && !stopped_ff && (sum1 <= {1'b0, cap_eff});
      stop1 = stopped_ff || (has1 && (sum1 > {1'b0, cap_eff}));
      bw1   = emit1 ? sum1[CAP_W-1:0] : bytes_written_ff;

      sum2  = {1'b0, bw1} + {{(CAP_W-2){1'b0}}, len2};
      emit2 = has2 && !stop1 && (sum2 <= {1'b0, cap_eff});
      stop2 = stop1 || (has2 && (sum2 > {1'b0, cap_eff}));
      bw2   = emit2 ? sum2[CAP_W-1:0] : bw1;

      cmd_wr_en          = accept && (emit1 || emit2 || final_unit);
      cmd_wr_data.cp1    = cp1;
      cmd_wr_data.len1   = emit1 ? len1 : 3'd0;
      cmd_wr_data.cp2    = cp2;
      cmd_wr_data.len2   = emit2 ? len2 : 3'd0;
      cmd_wr_data.fin    = final_unit;
      cmd_wr_data.length = bw2;

      high_pending_in  = high_pending_ff;
      high_bits_in     = high_bits_ff;
      bytes_written_in = bytes_written_ff;
      stopped_in       = stopped_ff;
      if (accept) begin
         if (final_unit) begin
            high_pending_in  = 1'b0;
            high_bits_in     = 10'd0;
            bytes_written_in = '0;
            stopped_in       = 1'b0;
         end else begin
            high_pending_in  = fresh && is_high;
            high_bits_in     = (fresh && is_high) ? code_unit[9:0] : 10'd0;
            bytes_written_in = bw2;
            stopped_in       = stop2;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_pending_ff  <= 1'b0;
         high_bits_ff     <= 10'd0;
         bytes_written_ff <= '0;
         stopped_ff       <= 1'b0;
      end else begin
         high_pending_ff  <= high_pending_in;
         high_bits_ff     <= high_bits_in;
         bytes_written_ff <= bytes_written_in;
         stopped_ff       <= stopped_in;
      end
   end

endmodule

// ----- rtl/core/utt_cmd_fifo.sv -----
module utt_cmd_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  utt_pkg::cmd_type wr_data,
   input  logic             rd_en,
   output utt_pkg::cmd_type rd_data,
   output logic             full,
   output logic             empty
);
   import utt_pkg::*;

   cmd_type              slot_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CMD_CNT_W-1:0] count_ff;
   logic                 do_wr, do_rd;

   assign full    = (count_ff == CMD_CNT_W'(CMD_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_wr) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_rd) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_wr && !do_rd) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_rd && !do_wr) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ----- rtl/core/utt_back.sv -----
module utt_back (
   input  logic                      clock,
   input  logic                      reset,
   input  utt_pkg::cmd_type          cmd_data,
   input  logic                      cmd_empty,
   output logic                      cmd_rd_en,
   input  logic                      pop,
   output logic                      empty,
   output logic [7:0]                out_byte,
   output logic                      end_marker,
   output logic [utt_pkg::CAP_W-1:0] byte_count,
   output logic                      run_last
);
   import utt_pkg::*;

   typedef enum logic [1:0] {
      SEG_FIRST,
      SEG_SECOND,
      SEG_MARK
   } seg_type;

   cmd_type          cur_ff;
   logic             busy_ff;
   seg_type          seg_ff, seg_next, seg_start;
   logic [1:0]       idx_ff;
   logic             out_valid_ff;
   logic [7:0]       out_byte_ff;
   logic             end_marker_ff;
   logic [CAP_W-1:0] byte_count_ff;
   logic             run_last_ff;

   logic [2:0]       seg_len;
   logic [7:0]       byte_cur;
   logic             seg_end, item_last, advance, load;

   always_comb begin
      seg_len  = (seg_ff == SEG_FIRST) ? cur_ff.len1 : cur_ff.len2;
      byte_cur = 8'h00;
      case (seg_ff)
         SEG_FIRST:  byte_cur = utf8_byte(cur_ff.cp1, cur_ff.len1, idx_ff);
         SEG_SECOND: byte_cur = utf8_byte({5'd0, cur_ff.cp2}, cur_ff.len2, idx_ff);
         default:    byte_cur = 8'h00;
      endcase
      seg_end = (seg_ff == SEG_MARK) || (({1'b0, idx_ff} + 3'd1) == seg_len);

      item_last = 1'b0;
      seg_next  = SEG_MARK;
      case (seg_ff)
         SEG_FIRST: begin
            if (cur_ff.len2 != 3'd0) begin
               seg_next = SEG_SECOND;
            end else begin
               seg_next  = SEG_MARK;
               item_last = !cur_ff.fin;
            end
         end
         SEG_SECOND: begin
            seg_next  = SEG_MARK;
            item_last = !cur_ff.fin;
         end
         default: begin
            seg_next  = SEG_MARK;
            item_last = 1'b1;
         end
      endcase
      item_last = item_last && seg_end;

      if (cmd_data.len1 != 3'd0) begin
         seg_start = SEG_FIRST;
      end else if (cmd_data.len2 != 3'd0) begin
         seg_start = SEG_SECOND;
      end else begin
         seg_start = SEG_MARK;
      end

      advance   = busy_ff && (!out_valid_ff || pop);
      load      = (!busy_ff || (advance && item_last)) && !cmd_empty;
      cmd_rd_en = load;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         seg_ff       <= SEG_FIRST;
         idx_ff       <= 2'd0;
      end else begin
         if (advance) begin
            out_valid_ff  <= 1'b1;
            out_byte_ff   <= byte_cur;
            end_marker_ff <= (seg_ff == SEG_MARK);
            byte_count_ff <= (seg_ff == SEG_MARK) ? cur_ff.length : '0;
            run_last_ff   <= item_last;
         end else if (pop) begin
            out_valid_ff <= 1'b0;
         end
         if (load) begin
            cur_ff  <= cmd_data;
            busy_ff <= 1'b1;
            seg_ff  <= seg_start;
            idx_ff  <= 2'd0;
         end else if (advance) begin
            if (item_last) begin
               busy_ff <= 1'b0;
            end else if (seg_end) begin
               seg_ff <= seg_next;
               idx_ff <= 2'd0;
            end else begin
               idx_ff <= idx_ff + 2'd1;
            end
         end
      end
   end

   assign empty      = !out_valid_ff;
   assign out_byte   = out_byte_ff;
   assign end_marker = end_marker_ff;
   assign byte_count = byte_count_ff;
   assign run_last   = run_last_ff;

   a_marker_ends_run: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && end_marker_ff |-> run_last_ff)
      else $error("end marker without run_last");

   a_marker_zero_byte: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && end_marker_ff |-> out_byte_ff == 8'h00)
      else $error("end marker carries a byte");

   a_byte_no_length: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !end_marker_ff |-> byte_count_ff == '0)
      else $error("byte result carries a length");

   a_no_read_when_empty: assert property (@(posedge clock) disable iff (reset)
      cmd_rd_en |-> !cmd_empty)
      else $error("command read from empty queue");

endmodule

// ----- rtl/core/utf16_to_utf8_transcoder_top.sv -----
// Channel   | Ports                                          | Handshake
// ----------+------------------------------------------------+---------------------------
// request   | req_code_unit, req_final_unit                  | push / full
// result    | rsp_out_byte, rsp_end_marker, rsp_byte_count,  | empty / pop
//           | rsp_run_last                                   |
// csr       | paddr, pwdata, prdata (capacity_bytes at 0)    | psel, penable, pwrite, pready
//
// One request is taken per cycle while the command queue has room; pairing and the
// capacity check finish in that cycle. The back end emits one result per cycle while
// results are popped; a request gives one result per byte, 1 to 6 bytes, plus the end
// marker on the last unit. Requests that emit nothing write no command and give no
// result. A stalled pop fills the four-entry command queue, then full rises.
// Synchronous reset clears string state, queue and result register; capacity returns to 1024.
module utf16_to_utf8_transcoder_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  logic [15:0]                         req_code_unit,
   input  logic                                req_final_unit,
   output logic                                empty,
   input  logic                                pop,
   output logic [7:0]                          rsp_out_byte,
   output logic                                rsp_end_marker,
   output logic [utt_pkg::CAP_W-1:0]           rsp_byte_count,
   output logic                                rsp_run_last,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [utt_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [utt_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [utt_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready
);
   import utt_pkg::*;

   logic [CAP_W-1:0] capacity_ff;
   logic             cap_sel;
   logic             accept;
   logic             cmd_wr_en, cmd_rd_en, cmd_full, cmd_empty;
   cmd_type          cmd_wr_data, cmd_rd_data;

   assign pready  = 1'b1;
   assign cap_sel = (paddr[CSR_ADDR_W-1:2] == CSR_CAPACITY_ADDR[CSR_ADDR_W-1:2]);
   assign prdata  = cap_sel ? {{(CSR_DATA_W-CAP_W){1'b0}}, capacity_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else if (psel && penable && pwrite && pready && cap_sel) begin
         capacity_ff <= pwdata[CAP_W-1:0];
      end
   end

   assign full   = cmd_full;
   assign accept = push && !cmd_full;

   utt_front u_front (
      .clock       (clock),
      .reset       (reset),
      .capacity    (capacity_ff),
      .accept      (accept),
      .code_unit   (req_code_unit),
      .final_unit  (req_final_unit),
      .cmd_wr_en   (cmd_wr_en),
      .cmd_wr_data (cmd_wr_data)
   );

   utt_cmd_fifo u_cmd_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (cmd_wr_en),
      .wr_data (cmd_wr_data),
      .rd_en   (cmd_rd_en),
      .rd_data (cmd_rd_data),
      .full    (cmd_full),
      .empty   (cmd_empty)
   );

   utt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_data   (cmd_rd_data),
      .cmd_empty  (cmd_empty),
      .cmd_rd_en  (cmd_rd_en),
      .pop        (pop),
      .empty      (empty),
      .out_byte   (rsp_out_byte),
      .end_marker (rsp_end_marker),
      .byte_count (rsp_byte_count),
      .run_last   (rsp_run_last)
   );

endmodule
